// ===== hw/rtl/control_report_change_events_defines.svh =====
// assertion macros for the control report change event block
`ifndef CONTROL_REPORT_CHANGE_EVENTS_DEFINES_SVH
`define CONTROL_REPORT_CHANGE_EVENTS_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRE_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("cre check failed");

// next-cycle implication, sampled on clk, off during reset
`define CRE_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("cre check failed");

`endif

// ===== hw/rtl/cre_pkg.sv =====
// types, constants and decode functions for the control report change event block
package cre_pkg;

	localparam int REPORT_BYTES_DEF = 22;
	localparam int STORE_BYTES      = 22;
	localparam int NUM_BUTTONS      = 29;
	localparam int NUM_ANALOG       = 8;
	localparam int NUM_CTRL         = NUM_BUTTONS + NUM_ANALOG + 1;
	localparam int CTRL_W           = $clog2(NUM_CTRL);
	localparam int FIRST_SPECIAL    = 16;
	localparam int FIRST_STOP       = 25;
	localparam int FIRST_FADER      = NUM_BUTTONS;
	localparam int FIRST_KNOB       = NUM_BUTTONS + 4;
	localparam int WHEEL_CTRL       = NUM_BUTTONS + NUM_ANALOG;
	localparam logic [7:0] ID_RESET = 8'd1;

	typedef enum logic [2:0] {
		SRC_MATRIX  = 3'd0,
		SRC_SPECIAL = 3'd1,
		SRC_STOP    = 3'd2,
		SRC_FADER   = 3'd3,
		SRC_KNOB    = 3'd4,
		SRC_WHEEL   = 3'd5
	} src_t;

	typedef logic [STORE_BYTES-1:0][7:0] store_t;
	typedef logic [NUM_CTRL-1:0] mask_t;
	typedef logic [CTRL_W-1:0] ctrl_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0]           buttons;
		logic [7:0]                       wheel;
		logic [NUM_ANALOG-1:0][15:0]      analog;
	} snap_t;

	typedef struct packed {
		logic              event_class;
		src_t              control_source;
		logic [3:0]        control_index;
		logic [15:0]       control_level;
		logic signed [7:0] wheel_step;
		logic              last_event;
	} evt_t;

	function automatic snap_t cre_decode(input store_t s);
		snap_t r;
		r = '0;
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 8; j++)
				r.buttons[j + 8 * i] = s[1 + i][7 - j];
		for (int k = 0; k < 6; k++)
			r.buttons[16 + k] = s[3][k + 2];
		for (int k = 0; k < 3; k++)
			r.buttons[22 + k] = s[4][k + 1];
		for (int k = 0; k < 4; k++)
			r.buttons[25 + k] = s[4][7 - k];
		r.wheel = s[5];
		for (int i = 0; i < 4; i++) begin
			r.analog[4 + i] = {s[7 + 2 * i], s[6 + 2 * i]};
			r.analog[i]     = {s[15 + 2 * i], s[14 + 2 * i]};
		end
		return r;
	endfunction

	// lowest set bit of the change mask
	function automatic ctrl_t cre_first(input mask_t m);
		ctrl_t r;
		r = '0;
		for (int i = NUM_CTRL - 1; i >= 0; i--)
			if (m[i])
				r = CTRL_W'(i);
		return r;
	endfunction

	function automatic evt_t cre_event(input snap_t s, input ctrl_t k,
		input logic [7:0] step);
		evt_t  e;
		ctrl_t off;
		e = '0;
		off = '0;
		case (k) inside
			[0:FIRST_SPECIAL-1]: begin
				e.control_source = SRC_MATRIX;
				e.control_index  = k[3:0];
				e.control_level  = {15'd0, s.buttons[k[4:0]]};
			end
			[FIRST_SPECIAL:FIRST_STOP-1]: begin
				off = k - CTRL_W'(FIRST_SPECIAL);
				e.control_source = SRC_SPECIAL;
				e.control_index  = off[3:0];
				e.control_level  = {15'd0, s.buttons[k[4:0]]};
			end
			[FIRST_STOP:FIRST_FADER-1]: begin
				off = k - CTRL_W'(FIRST_STOP);
				e.control_source = SRC_STOP;
				e.control_index  = off[3:0];
				e.control_level  = {15'd0, s.buttons[k[4:0]]};
			end
			[FIRST_FADER:FIRST_KNOB-1]: begin
				off = k - CTRL_W'(FIRST_FADER);
				e.event_class    = 1'b1;
				e.control_source = SRC_FADER;
				e.control_index  = {2'd0, off[1:0]};
				e.control_level  = s.analog[off[2:0]];
			end
			[FIRST_KNOB:WHEEL_CTRL-1]: begin
				off = k - CTRL_W'(FIRST_FADER);
				e.event_class    = 1'b1;
				e.control_source = SRC_KNOB;
				e.control_index  = {2'd0, off[1:0]};
				e.control_level  = s.analog[off[2:0]];
			end
			default: begin
				e.event_class    = 1'b1;
				e.control_source = SRC_WHEEL;
				e.control_level  = {8'd0, s.wheel};
				e.wheel_step     = step;
			end
		endcase
		return e;
	endfunction

endpackage

// ===== hw/rtl/control_report_change_events_if.sv =====
// channel interfaces of the control report change event block
interface cre_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte;
	logic       end_of_report;
	modport source (output valid, report_byte, end_of_report, input ready);
	modport sink (input valid, report_byte, end_of_report, output ready);
endinterface

interface cre_event_if;
	logic              valid;
	logic              ready;
	logic              event_class;
	logic [2:0]        control_source;
	logic [3:0]        control_index;
	logic [15:0]       control_level;
	logic signed [7:0] wheel_step;
	logic              last_event;
	modport source (output valid, event_class, control_source, control_index,
		control_level, wheel_step, last_event, input ready);
	modport sink (input valid, event_class, control_source, control_index,
		control_level, wheel_step, last_event, output ready);
endinterface

interface cre_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/cre_front.sv =====
// front end: report byte capture, id check and snapshot decode
module cre_front
	import cre_pkg::*;
#(
	parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cre_byte_if.sink    report_in,
	cre_cfg_if.sink     cfg,
	output logic        snap_valid,
	input  logic        snap_ready,
	output snap_t       snap
);

	localparam int POS_W = $clog2(REPORT_BYTES + 1);

	logic [POS_W-1:0] pos_q;
	store_t           store_q;
	logic [7:0]       id_q;
	logic             pending_q;
	logic             accept;
	logic             match;

	assign report_in.ready = !pending_q;
	assign cfg.ready       = 1'b1;
	assign accept          = report_in.valid && report_in.ready;
	assign match           = store_q[0] == id_q;
	assign snap_valid      = pending_q && match;
	assign snap            = cre_decode(store_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			pending_q <= 1'b0;
			id_q      <= ID_RESET;
		end else begin
			if (cfg.valid)
				id_q <= cfg.data;
			if (accept) begin
				if (report_in.end_of_report) begin
					pos_q     <= '0;
					pending_q <= 1'b1;
				end else if (pos_q < POS_W'(REPORT_BYTES)) begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (pending_q && (!match || snap_ready)) begin
				pending_q <= 1'b0;
			end
		end
	end

	for (genvar e = 0; e < STORE_BYTES; e++) begin : g_store
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				store_q[e] <= '0;
			else if (accept && pos_q == POS_W'(e))
				store_q[e] <= report_in.report_byte;
		end
	end

endmodule

// ===== hw/rtl/cre_queue.sv =====
// two-entry snapshot queue between front and back
module cre_queue
	import cre_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  snap_t in_snap,
	output logic  out_valid,
	input  logic  out_ready,
	output snap_t out_snap
);

	snap_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = count_q != 2'd2;
	assign out_valid = count_q != 2'd0;
	assign out_snap  = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= in_snap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== hw/rtl/cre_back.sv =====
// back end: change detection against the previous snapshot and event scan
`include "control_report_change_events_defines.svh"
module cre_back
	import cre_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        snap_valid,
	output logic        snap_ready,
	input  snap_t       snap,
	cre_event_if.source event_out
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t     state_q;
	snap_t      prev_q;
	snap_t      cur_q;
	mask_t      mask_q;
	logic [7:0] step_q;
	evt_t       evt_q;
	logic       ov_q;
	mask_t      new_mask;
	mask_t      rest;
	ctrl_t      sel;
	evt_t       evt;
	logic       load;
	logic       emit;

	always_comb begin
		new_mask = '0;
		new_mask[NUM_BUTTONS-1:0] = snap.buttons ^ prev_q.buttons;
		for (int i = 0; i < NUM_ANALOG; i++)
			new_mask[NUM_BUTTONS + i] = snap.analog[i] != prev_q.analog[i];
		new_mask[WHEEL_CTRL] = snap.wheel != prev_q.wheel;
	end

	assign snap_ready = state_q == ST_IDLE;
	assign load       = snap_valid && snap_ready;
	assign emit       = state_q == ST_SCAN && (!ov_q || event_out.ready);
	assign sel        = cre_first(mask_q);
	assign rest       = mask_q & ~(mask_t'(1) << sel);

	always_comb begin
		evt = cre_event(cur_q, sel, step_q);
		evt.last_event = rest == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q  <= '0;
			mask_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (emit)
				ov_q <= 1'b1;
			else if (event_out.ready)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						prev_q <= snap;
						mask_q <= new_mask;
						if (new_mask != '0)
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (emit) begin
						mask_q <= rest;
						if (rest == '0)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q  <= snap;
			step_q <= snap.wheel - prev_q.wheel;
		end
		if (emit)
			evt_q <= evt;
	end

	assign event_out.valid          = ov_q;
	assign event_out.event_class    = evt_q.event_class;
	assign event_out.control_source = evt_q.control_source;
	assign event_out.control_index  = evt_q.control_index;
	assign event_out.control_level  = evt_q.control_level;
	assign event_out.wheel_step     = evt_q.wheel_step;
	assign event_out.last_event     = evt_q.last_event;

	`CRE_ASSERT_NOW(a_idle_no_mask, state_q == ST_IDLE, mask_q == '0)
	`CRE_ASSERT_NOW(a_scan_has_mask, state_q == ST_SCAN, mask_q != '0)
	`CRE_ASSERT_NEXT(a_last_ends_scan, emit && evt.last_event, state_q == ST_IDLE)
	`CRE_ASSERT_NOW(a_wheel_step, ov_q && evt_q.control_source == SRC_WHEEL,
		evt_q.wheel_step != 8'sd0)
	`CRE_ASSERT_NOW(a_other_step, ov_q && evt_q.control_source != SRC_WHEEL,
		evt_q.wheel_step == 8'sd0)

endmodule

// ===== hw/rtl/control_report_change_events.sv =====
// top level: report decoder with change events
// report bytes are stored as taken; the final byte stalls input for id check and decode
// the first event reaches the output register via the queue and the back end change mask
// events follow one per cycle while ready is high, set by the scan over the change mask
// a queue of two decoded reports lets the front take new bytes while events drain
// arst_n clears the store, the snapshot and all control state; id register resets to 1
module control_report_change_events
	import cre_pkg::*;
#(
	parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cre_byte_if.sink    report_in,
	cre_cfg_if.sink     cfg,
	cre_event_if.source event_out
);

	logic  fq_valid;
	logic  fq_ready;
	snap_t fq_snap;
	logic  qb_valid;
	logic  qb_ready;
	snap_t qb_snap;

	cre_front #(
		.REPORT_BYTES(REPORT_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.report_in  (report_in),
		.cfg        (cfg),
		.snap_valid (fq_valid),
		.snap_ready (fq_ready),
		.snap       (fq_snap)
	);

	cre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_snap   (fq_snap),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_snap  (qb_snap)
	);

	cre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (qb_valid),
		.snap_ready (qb_ready),
		.snap       (qb_snap),
		.event_out  (event_out)
	);

endmodule
